// ===== src/sle_pkg.sv =====
// Shared types and constants for the serial line editor.
// Used by sle_line_ram, sle_ctrl and serial_line_editor; depends on nothing.
package sle_pkg;

	localparam int LINE_MAX = 63;
	localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
	localparam int LW = $clog2(LINE_MAX + 1);

	localparam logic [LW-1:0] LEN_MAX = LW'(LINE_MAX);

	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	localparam int CFG_IW = 1;
	localparam logic [CFG_IW-1:0] REG_ECHO_ON   = 1'b0;
	localparam logic [CFG_IW-1:0] REG_PROMPT_ON = 1'b1;

	typedef enum logic [1:0] {
		KIND_ECHO   = 2'd0,
		KIND_CMD    = 2'd1,
		KIND_PROMPT = 2'd2,
		KIND_CANCEL = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ECHO,
		ST_BS1,
		ST_SP,
		ST_BS2,
		ST_CMD,
		ST_CANCEL,
		ST_PROMPT
	} state_t;

	typedef struct packed {
		logic echo_on;
		logic prompt_on;
	} cfg_t;

	typedef struct packed {
		logic          valid;
		kind_t         kind;
		logic [7:0]    data;
		logic          line_end;
		logic          last;
	} emit_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [7:0]    wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} ram_req_t;

endpackage

// ===== src/serial_line_editor.sv =====
// Top level of the serial line editor: config registers, output register,
// and the edit sequencer. Depends on sle_pkg, sle_ctrl.
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   rx_byte
//  output    out        out_valid / out_stall kind, data_byte, line_end, last
//  config    in         cfg_we                cfg_index, cfg_data
//
// One received byte is taken per request; in_stall stays high until all its
// results have been handed to the output register.
// With echo on, a printable byte is echoed and an erase is echoed as
// backspace, space, backspace; a cancel is followed by a prompt if enabled.
// A line end sends the stored bytes, then a prompt when prompts are on: the
// line memory gives one byte per cycle on its single read port unless stalled.
// Output stalls freeze the sequencer. Reset clears the line and sets both
// config bits; no clearing pass is needed.
module serial_line_editor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                rx_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                kind,
	output logic [7:0]                data_byte,
	output logic                      line_end,
	output logic                      last,
	input  logic                      cfg_we,
	input  logic [sle_pkg::CFG_IW-1:0] cfg_index,
	input  logic                      cfg_data
);
	import sle_pkg::*;

	logic  echo_on_q, prompt_on_q;
	cfg_t  cfg;
	emit_t emit;
	logic  out_free;
	logic  out_valid_q;
	emit_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_on_q   <= 1'b1;
			prompt_on_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ECHO_ON:   echo_on_q   <= cfg_data;
				REG_PROMPT_ON: prompt_on_q <= cfg_data;
			endcase
		end
	end

	assign cfg.echo_on   = echo_on_q;
	assign cfg.prompt_on = prompt_on_q;

	assign out_free = ~out_valid_q | ~out_stall;

	sle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.cfg      (cfg),
		.out_free (out_free),
		.emit     (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit.valid) begin
			out_q <= emit;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_q.kind;
	assign data_byte = out_q.data;
	assign line_end  = out_q.line_end;
	assign last      = out_q.last;

	a_line_end_is_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_end |-> kind == KIND_CMD)
		else $error("line_end on a non command result");

	a_notice_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_PROMPT || kind == KIND_CANCEL) |-> data_byte == 8'h00)
		else $error("prompt or cancel result carries data");

	a_prompt_follows_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_end && prompt_on_q |-> !last)
		else $error("line end marked last while a prompt is due");

	a_busy_while_results: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input taken before all results were issued");

endmodule

// ===== src/sle_line_ram.sv =====
// Line buffer storage: one write port, one read port, registered read data.
// Depends on sle_pkg.
module sle_line_ram (
	input  logic              clk,
	input  sle_pkg::ram_req_t req,
	output logic [7:0]        rd_data
);
	import sle_pkg::*;

	logic [7:0] mem [LINE_MAX];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// read data holds until the next read, so a stalled output keeps its byte
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data_q <= mem[req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/sle_ctrl.sv =====
// Edit sequencer: decodes each received byte, updates the line buffer and
// length, and issues the results one at a time. Depends on sle_pkg, sle_line_ram.
module sle_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     rx_byte,
	input  sle_pkg::cfg_t  cfg,
	input  logic           out_free,
	output sle_pkg::emit_t emit
);
	import sle_pkg::*;

	state_t        state_q, state_d;
	logic [LW-1:0] len_q, len_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [7:0]    byte_q, byte_d;
	ram_req_t      ram;
	logic [7:0]    ram_rdata;
	logic          cmd_end;

	sle_line_ram u_ram (
		.clk     (clk),
		.req     (ram),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
	end

	assign cmd_end = (LW'(idx_q) + LW'(1)) == len_q;

	always_comb begin
		state_d  = state_q;
		len_d    = len_q;
		idx_d    = idx_q;
		byte_d   = byte_q;
		ram      = '0;
		emit     = '0;
		in_stall = (state_q != ST_IDLE);

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					priority if (rx_byte == CH_CR || rx_byte == CH_LF) begin
						if (len_q != '0) begin
							ram.re    = 1'b1;
							ram.raddr = '0;
							idx_d     = '0;
							state_d   = ST_CMD;
						end else if (cfg.prompt_on) begin
							state_d = ST_PROMPT;
						end
					end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
						if (len_q != '0) begin
							len_d = len_q - LW'(1);
							if (cfg.echo_on) begin
								state_d = ST_BS1;
							end
						end
					end else if (rx_byte == CH_ETX) begin
						len_d   = '0;
						state_d = ST_CANCEL;
					end else if (rx_byte >= CH_SPACE && rx_byte <= CH_TILDE) begin
						// full line: byte dropped silently
						if (len_q < LEN_MAX) begin
							ram.we    = 1'b1;
							ram.waddr = AW'(len_q);
							ram.wdata = rx_byte;
							len_d     = len_q + LW'(1);
							byte_d    = rx_byte;
							if (cfg.echo_on) begin
								state_d = ST_ECHO;
							end
						end
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ECHO: begin
				emit.valid = 1'b1;
				emit.kind  = KIND_ECHO;
				emit.data  = byte_q;
				emit.last  = 1'b1;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_BS1: begin
				emit.valid = 1'b1;
				emit.kind  = KIND_ECHO;
				emit.data  = CH_BS;
				if (out_free) begin
					state_d = ST_SP;
				end
			end
			ST_SP: begin
				emit.valid = 1'b1;
				emit.kind  = KIND_ECHO;
				emit.data  = CH_SPACE;
				if (out_free) begin
					state_d = ST_BS2;
				end
			end
			ST_BS2: begin
				emit.valid = 1'b1;
				emit.kind  = KIND_ECHO;
				emit.data  = CH_BS;
				emit.last  = 1'b1;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_CMD: begin
				// ram_rdata holds entry idx_q; next read goes out with this request
				emit.valid    = 1'b1;
				emit.kind     = KIND_CMD;
				emit.data     = ram_rdata;
				emit.line_end = cmd_end;
				emit.last     = cmd_end & ~cfg.prompt_on;
				if (out_free) begin
					if (cmd_end) begin
						len_d   = '0;
						state_d = cfg.prompt_on ? ST_PROMPT : ST_IDLE;
					end else begin
						ram.re    = 1'b1;
						ram.raddr = idx_q + AW'(1);
						idx_d     = idx_q + AW'(1);
					end
				end
			end
			ST_CANCEL: begin
				emit.valid = 1'b1;
				emit.kind  = KIND_CANCEL;
				emit.last  = ~cfg.prompt_on;
				if (out_free) begin
					state_d = cfg.prompt_on ? ST_PROMPT : ST_IDLE;
				end
			end
			ST_PROMPT: begin
				emit.valid = 1'b1;
				emit.kind  = KIND_PROMPT;
				emit.last  = 1'b1;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

endmodule
